FILE: design/vt_stream_row_router_top_macros.svh
// Assertion macros for the terminal row router.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef VT_STREAM_ROW_ROUTER_TOP_MACROS_SVH
`define VT_STREAM_ROW_ROUTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define VT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define VT_ASSERT(label, clk, rst_n, prop)
`define VT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: design/vt_srr_pkg.sv
// Shared types and constants for the terminal row router.
// No dependencies; used by every module of the block.
package vt_srr_pkg;

  localparam int unsigned MAX_ROWS             = 256;
  localparam int unsigned ROW_LIMIT_CAP        = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int unsigned SEQ_BUFFER_BYTES_DEF = 64;
  localparam int unsigned CMD_FIFO_DEPTH       = 4;
  localparam int unsigned LEN_W                = 8;
  localparam int unsigned ROW_W                = 8;
  localparam int unsigned ROW_COUNT_W          = 9;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd24;
  localparam logic [15:0] ACC_MAX = 16'hFFFF;

  localparam logic [7:0] CHAR_ESC       = 8'h1B;
  localparam logic [7:0] CHAR_BEL       = 8'h07;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHAR_H         = 8'h48;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_0         = 8'h30;
  localparam logic [7:0] CHAR_9         = 8'h39;
  localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI   = 8'h7E;

  typedef enum logic [1:0] {
    CMD_ONE   = 2'd0,
    CMD_TWO   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_kind_e;

  // One queued job for the back end: one byte, two bytes, or a buffered sequence
  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic             alw;
    logic [ROW_W-1:0] row;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

FILE: design/vt_srr_in_if.sv
// Input byte channel of the terminal row router.
// Uses no package.
interface vt_srr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

FILE: design/vt_srr_out_if.sv
// Result channel of the terminal row router.
// Uses no package.
interface vt_srr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_always;
  logic [7:0] dest_row;
  logic       last;

  modport source (output valid, output out_byte, output to_always, output dest_row,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input to_always, input dest_row,
                  input last, output ready);
endinterface

FILE: design/vt_stream_row_router_top.sv
// Terminal row router: tags each forwarded byte with a screen row or the always stream.
// Result path: queue entry, back end command register, output register.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
// the back end drives one result per cycle while out ready is high, one per CSI byte.
// A new CSI byte waits while the previous CSI burst is still in the queue or draining.
// Reset: asynchronous, clears parser and queue state; the CSI buffer is not cleared.
module vt_stream_row_router_top import vt_srr_pkg::*; #(
  parameter int unsigned SEQ_BUFFER_BYTES = SEQ_BUFFER_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  vt_srr_in_if.sink              in_i,
  vt_srr_out_if.source           out_o,
  input  logic                   cfg_we_i,
  input  logic [ROW_COUNT_W-1:0] cfg_wdata_i
);

  logic    cmd_push;
  cmd_t    cmd_in;
  logic    fifo_full;
  logic    cmd_valid;
  cmd_t    cmd_out;
  logic    cmd_pop;
  logic    flush_done;
  buf_wr_t buf_wr;

  vt_srr_front #(
    .SEQ_BUFFER_BYTES(SEQ_BUFFER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_full_i (fifo_full),
    .flush_done_i(flush_done),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .buf_wr_o    (buf_wr)
  );

  vt_srr_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (fifo_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_out)
  );

  vt_srr_back #(
    .SEQ_BUFFER_BYTES(SEQ_BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .buf_wr_i    (buf_wr),
    .flush_done_o(flush_done),
    .out_o       (out_o)
  );

endmodule

FILE: design/vt_srr_front.sv
// Parser front end: accepts bytes, tracks ESC/CSI/OSC state and the row register.
// Depends on vt_srr_pkg and vt_srr_in_if; feeds the command queue and the buffer.
module vt_srr_front import vt_srr_pkg::*; #(
  parameter int unsigned SEQ_BUFFER_BYTES = SEQ_BUFFER_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  vt_srr_in_if.sink              in_i,
  input  logic                   cfg_we_i,
  input  logic [ROW_COUNT_W-1:0] cfg_wdata_i,
  input  logic                   fifo_full_i,
  input  logic                   flush_done_i,
  output logic                   cmd_push_o,
  output cmd_t                   cmd_o,
  output buf_wr_t                buf_wr_o
);

  localparam int unsigned BufCap = SEQ_BUFFER_BYTES - 1;
  localparam int unsigned IdxW   = $clog2(SEQ_BUFFER_BYTES);

  localparam logic [2:0] ST_TEXT    = 3'd0;
  localparam logic [2:0] ST_ESC     = 3'd1;
  localparam logic [2:0] ST_CSI     = 3'd2;
  localparam logic [2:0] ST_OSC     = 3'd3;
  localparam logic [2:0] ST_OSC_END = 3'd4;

  logic [2:0]             state_q, state_d;
  logic                   alw_q, alw_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [IdxW-1:0]        len_q, len_d;
  logic [15:0]            acc_q, acc_d;
  logic                   seen_q, seen_d;
  logic                   ended_q, ended_d;
  logic                   flush_busy_q;
  logic [ROW_COUNT_W-1:0] row_count_q;

  logic                   accept;
  logic [7:0]             ch;
  logic                   is_digit;
  logic                   is_final;
  logic [19:0]            acc_next;
  logic [15:0]            target;
  logic [ROW_COUNT_W-1:0] row_limit;
  logic [IdxW-1:0]        len_inc;

  assign ch     = in_i.data_byte;
  assign in_i.ready = !fifo_full_i && !((state_q == ST_CSI) && flush_busy_q);
  assign accept = in_i.valid && in_i.ready;

  assign is_digit = (ch >= CHAR_0) && (ch <= CHAR_9);
  assign is_final = (ch >= CSI_FINAL_LO) && (ch <= CSI_FINAL_HI);
  // acc * 10 + digit, as shifts
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {12'd0, ch - CHAR_0};
  assign target   = seen_q ? (acc_q - 16'd1) : 16'd0;
  assign row_limit = (row_count_q > ROW_COUNT_W'(ROW_LIMIT_CAP)) ?
                     ROW_COUNT_W'(ROW_LIMIT_CAP) : row_count_q;
  assign len_inc  = IdxW'(len_q + IdxW'(1));

  always_comb begin
    state_d    = state_q;
    alw_d      = alw_q;
    row_d      = row_q;
    len_d      = len_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    ended_d    = ended_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_ONE, b0: ch, b1: ch, alw: alw_q, row: row_q, len: '0};
    buf_wr_o   = '{we: 1'b0, addr: LEN_W'(len_q), data: ch};
    if (accept) begin
      unique case (state_q)
        ST_TEXT: begin
          if (ch == CHAR_ESC) begin
            state_d = ST_ESC;
          end else begin
            cmd_push_o = 1'b1;
          end
        end
        ST_ESC: begin
          if (ch == CHAR_LBRACKET) begin
            // ESC and '[' are implied at the head of every flush
            state_d = ST_CSI;
            len_d   = IdxW'(2);
            acc_d   = '0;
            seen_d  = 1'b0;
            ended_d = 1'b0;
          end else if (ch == CHAR_RBRACKET) begin
            cmd_push_o = 1'b1;
            cmd_o.kind = CMD_TWO;
            cmd_o.b0   = CHAR_ESC;
            cmd_o.alw  = 1'b1;
            state_d    = ST_OSC;
          end else begin
            cmd_push_o = 1'b1;
            cmd_o.kind = CMD_TWO;
            cmd_o.b0   = CHAR_ESC;
            state_d    = ST_TEXT;
          end
        end
        ST_CSI: begin
          if (len_q < IdxW'(BufCap)) begin
            buf_wr_o.we = 1'b1;
            len_d       = len_inc;
            if (!ended_q) begin
              if (is_digit) begin
                acc_d  = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[15:0];
                seen_d = 1'b1;
              end else begin
                ended_d = 1'b1;
              end
            end
          end
          if (is_final) begin
            // final byte is never a digit, so the row parameter is already settled
            if ((ch == CHAR_H) || (ch == CHAR_F)) begin
              if (seen_q && (acc_q == 16'd0)) begin
                alw_d = 1'b1;
              end else if (target < {7'd0, row_limit}) begin
                alw_d = 1'b0;
                row_d = target[ROW_W-1:0];
              end
            end
            cmd_push_o = 1'b1;
            cmd_o.kind = CMD_FLUSH;
            cmd_o.alw  = alw_d;
            cmd_o.row  = row_d;
            cmd_o.len  = LEN_W'(len_d);
            len_d      = '0;
            state_d    = ST_TEXT;
          end
        end
        ST_OSC: begin
          if (ch == CHAR_BEL) begin
            cmd_push_o = 1'b1;
            cmd_o.alw  = 1'b1;
            alw_d      = 1'b1;
            state_d    = ST_TEXT;
          end else if (ch == CHAR_ESC) begin
            state_d = ST_OSC_END;
          end else begin
            cmd_push_o = 1'b1;
            cmd_o.alw  = 1'b1;
          end
        end
        ST_OSC_END: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_TWO;
          cmd_o.b0   = CHAR_ESC;
          cmd_o.alw  = 1'b1;
          alw_d      = 1'b1;
          state_d    = ST_TEXT;
        end
        default: begin
          state_d = ST_TEXT;
        end
      endcase
      // drop any open sequence and select the always stream at a write buffer end
      if (in_i.end_of_buffer) begin
        state_d = ST_TEXT;
        alw_d   = 1'b1;
        row_d   = '0;
        len_d   = '0;
        acc_d   = '0;
        seen_d  = 1'b0;
        ended_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_TEXT;
      alw_q        <= 1'b1;
      row_q        <= '0;
      len_q        <= '0;
      acc_q        <= '0;
      seen_q       <= 1'b0;
      ended_q      <= 1'b0;
      flush_busy_q <= 1'b0;
      row_count_q  <= ROW_COUNT_RESET;
    end else begin
      state_q <= state_d;
      alw_q   <= alw_d;
      row_q   <= row_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      ended_q <= ended_d;
      // hold new CSI bytes until the back end has read out the previous sequence
      if (cmd_push_o && (cmd_o.kind == CMD_FLUSH)) begin
        flush_busy_q <= 1'b1;
      end else if (flush_done_i) begin
        flush_busy_q <= 1'b0;
      end
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: design/vt_srr_cmd_fifo.sv
// Short command queue between the parser front end and the output back end.
// Depends on vt_srr_pkg.
module vt_srr_cmd_fifo import vt_srr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            entries_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(CMD_FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + PtrW'(1));
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + PtrW'(1));
      end
      if (do_push && !do_pop) begin
        count_q <= CntW'(count_q + CntW'(1));
      end else if (do_pop && !do_push) begin
        count_q <= CntW'(count_q - CntW'(1));
      end
    end
  end

endmodule

FILE: design/vt_srr_back.sv
// Output back end: runs queued commands, holds the CSI buffer, drives results.
// Depends on vt_srr_pkg, vt_srr_out_if and the assertion macro header.
`include "vt_stream_row_router_top_macros.svh"
module vt_srr_back import vt_srr_pkg::*; #(
  parameter int unsigned SEQ_BUFFER_BYTES = SEQ_BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  buf_wr_t     buf_wr_i,
  output logic        flush_done_o,
  vt_srr_out_if.source out_o
);

  localparam int unsigned BufCap = SEQ_BUFFER_BYTES - 1;
  localparam int unsigned IdxW   = $clog2(SEQ_BUFFER_BYTES);

  logic [7:0]       seq_mem [BufCap];

  logic             busy_q;
  cmd_t             cur_q;
  logic [LEN_W-1:0] idx_q;

  logic             out_valid_q;
  logic             sel_mem_q;
  logic [7:0]       byte_q;
  logic [7:0]       rd_q;
  logic             alw_q;
  logic [ROW_W-1:0] row_q;
  logic             last_q;

  logic             adv;
  logic             emit;
  logic             at_last;
  logic [LEN_W-1:0] cnt;
  logic [7:0]       elem_byte;
  logic             elem_mem;

  always_comb begin
    case (cur_q.kind)
      CMD_TWO:   cnt = LEN_W'(2);
      CMD_FLUSH: cnt = cur_q.len;
      default:   cnt = LEN_W'(1);
    endcase
  end

  assign adv      = !out_valid_q || out_o.ready;
  assign emit     = busy_q && adv;
  assign at_last  = (LEN_W'(idx_q + LEN_W'(1)) == cnt);
  assign cmd_pop_o = cmd_valid_i && (!busy_q || (emit && at_last));
  assign flush_done_o = emit && at_last && (cur_q.kind == CMD_FLUSH);

  always_comb begin
    elem_mem  = 1'b0;
    elem_byte = cur_q.b0;
    case (cur_q.kind)
      CMD_TWO: begin
        elem_byte = (idx_q == '0) ? cur_q.b0 : cur_q.b1;
      end
      CMD_FLUSH: begin
        if (idx_q == '0) begin
          elem_byte = CHAR_ESC;
        end else if (idx_q == LEN_W'(1)) begin
          elem_byte = CHAR_LBRACKET;
        end else begin
          elem_mem = 1'b1;
        end
      end
      default: begin
        elem_byte = cur_q.b0;
      end
    endcase
  end

  // sequence buffer: one write port from the parser, one registered read port
  always_ff @(posedge clk_i) begin
    if (buf_wr_i.we) begin
      seq_mem[buf_wr_i.addr[IdxW-1:0]] <= buf_wr_i.data;
    end
    if (emit) begin
      rd_q <= seq_mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sel_mem_q <= elem_mem;
      byte_q    <= elem_byte;
      alw_q     <= cur_q.alw;
      row_q     <= cur_q.alw ? '0 : cur_q.row;
      last_q    <= at_last;
    end
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= emit;
      end
      if (cmd_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (at_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= LEN_W'(idx_q + LEN_W'(1));
        end
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = sel_mem_q ? rd_q : byte_q;
  assign out_o.to_always = alw_q;
  assign out_o.dest_row  = row_q;
  assign out_o.last      = last_q;

  `VT_ASSERT_NEVER(a_wr_during_flush, clk_i, rst_ni, buf_wr_i.we && busy_q && (cur_q.kind == CMD_FLUSH))
  `VT_ASSERT(a_idx_in_range, clk_i, rst_ni, busy_q |-> (idx_q < cnt))
  `VT_ASSERT(a_flush_has_head, clk_i, rst_ni, (busy_q && (cur_q.kind == CMD_FLUSH)) |-> (cur_q.len >= LEN_W'(2)))

endmodule

FILE: tb/vt_stream_row_router_top_tb.sv
`timescale 1ns / 1ps
// Testbench for vt_stream_row_router_top: sends terminal bytes, predicts the routed
// results in order and checks each one. Depends on vt_srr_pkg and the two channel interfaces.
module vt_stream_row_router_top_tb;
  import vt_srr_pkg::*;

  localparam int unsigned SEQ_CAP       = SEQ_BUFFER_BYTES_DEF - 1;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 8;

  typedef enum logic [2:0] {
    ST_TEXT,
    ST_ESC,
    ST_CSI,
    ST_OSC,
    ST_OSC_END
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       alw;
    logic [7:0] row;
    logic       last;
  } route_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [ROW_COUNT_W-1:0] cfg_wdata_i;

  vt_srr_in_if  in_if ();
  vt_srr_out_if out_if ();

  vt_stream_row_router_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Router state as predicted
  parse_state_e           pstate;
  logic                   cur_alw;
  logic [7:0]             cur_row;
  logic [7:0]             seq_buf [SEQ_CAP];
  int unsigned            seq_len;
  logic [15:0]            row_acc;
  logic                   dig_seen;
  logic                   dig_end;
  logic [ROW_COUNT_W-1:0] row_count_q;

  route_t      route_q[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  function automatic void clear_parser();
    pstate   = ST_TEXT;
    cur_alw  = 1'b1;
    cur_row  = 8'd0;
    seq_len  = 0;
    row_acc  = 16'd0;
    dig_seen = 1'b0;
    dig_end  = 1'b0;
  endfunction

  function automatic void push_route(logic [7:0] b, logic alw, logic [7:0] row);
    route_t r;
    r.data = b;
    r.alw  = alw;
    r.row  = alw ? 8'd0 : row;
    r.last = 1'b0;
    route_q.push_back(r);
  endfunction

  // Advance the predicted parser by one accepted request and queue what it routes
  function automatic void route_byte(logic [7:0] ch, logic eob);
    int unsigned n_prev;
    int unsigned acc_next;
    int unsigned target;
    int unsigned lim;
    int unsigned i;
    n_prev = route_q.size();
    case (pstate)
      ST_TEXT: begin
        if (ch == CHAR_ESC) pstate = ST_ESC;
        else push_route(ch, cur_alw, cur_row);
      end
      ST_ESC: begin
        if (ch == CHAR_LBRACKET) begin
          pstate     = ST_CSI;
          seq_buf[0] = CHAR_ESC;
          seq_buf[1] = CHAR_LBRACKET;
          seq_len    = 2;
          row_acc    = 16'd0;
          dig_seen   = 1'b0;
          dig_end    = 1'b0;
        end else if (ch == CHAR_RBRACKET) begin
          push_route(CHAR_ESC, 1'b1, 8'd0);
          push_route(ch, 1'b1, 8'd0);
          pstate = ST_OSC;
        end else begin
          push_route(CHAR_ESC, cur_alw, cur_row);
          push_route(ch, cur_alw, cur_row);
          pstate = ST_TEXT;
        end
      end
      ST_CSI: begin
        // Drop bytes once the buffer is full; a final byte still closes the sequence
        if (seq_len < SEQ_CAP) begin
          seq_buf[seq_len] = ch;
          seq_len++;
          if (!dig_end) begin
            if (ch >= CHAR_0 && ch <= CHAR_9) begin
              acc_next = row_acc * 10 + (ch - CHAR_0);
              row_acc  = (acc_next > ACC_MAX) ? ACC_MAX : acc_next[15:0];
              dig_seen = 1'b1;
            end else begin
              dig_end = 1'b1;
            end
          end
        end
        if (ch >= CSI_FINAL_LO && ch <= CSI_FINAL_HI) begin
          if (ch == CHAR_H || ch == CHAR_F) begin
            if (dig_seen && row_acc == 16'd0) begin
              cur_alw = 1'b1;
            end else begin
              target = dig_seen ? row_acc - 1 : 0;
              lim    = (row_count_q < ROW_LIMIT_CAP) ? row_count_q : ROW_LIMIT_CAP;
              if (target < lim) begin
                cur_alw = 1'b0;
                cur_row = target[7:0];
              end
            end
          end
          for (i = 0; i < seq_len; i++) push_route(seq_buf[i], cur_alw, cur_row);
          seq_len = 0;
          pstate  = ST_TEXT;
        end
      end
      ST_OSC: begin
        if (ch == CHAR_BEL) begin
          push_route(ch, 1'b1, 8'd0);
          cur_alw = 1'b1;
          pstate  = ST_TEXT;
        end else if (ch == CHAR_ESC) begin
          pstate = ST_OSC_END;
        end else begin
          push_route(ch, 1'b1, 8'd0);
        end
      end
      default: begin
        push_route(CHAR_ESC, 1'b1, 8'd0);
        push_route(ch, 1'b1, 8'd0);
        cur_alw = 1'b1;
        pstate  = ST_TEXT;
      end
    endcase
    if (route_q.size() > n_prev) route_q[route_q.size()-1].last = 1'b1;
    if (eob) clear_parser();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    route_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (route_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, byte %02h", out_if.out_byte));
      end else begin
        want = route_q.pop_front();
        if (out_if.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte, want.data));
        if (out_if.to_always !== want.alw)
          report_mismatch($sformatf("to_always %b, want %b (byte %02h)",
                                    out_if.to_always, want.alw, want.data));
        if (out_if.dest_row !== want.row)
          report_mismatch($sformatf("dest_row %0d, want %0d (byte %02h)",
                                    out_if.dest_row, want.row, want.data));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("last %b, want %b (byte %02h)",
                                    out_if.last, want.last, want.data));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_buffer <= eob;
    do @(posedge clk_i); while (!in_if.ready);
    route_byte(b, eob);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eob_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eob_last && (i == s.len() - 1));
  endtask

  // Hold the source until every expected result is back, then let the pipe settle
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (route_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_row_count(input logic [ROW_COUNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    row_count_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] non_final_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI);
    return b;
  endfunction

  function automatic logic rare_eob();
    return ($urandom_range(31) == 0);
  endfunction

  task automatic send_random_csi(input int unsigned n_digits, input int unsigned n_fill);
    int unsigned i;
    logic [7:0]  fin;
    send_byte(CHAR_ESC, rare_eob());
    send_byte(CHAR_LBRACKET, rare_eob());
    for (i = 0; i < n_digits; i++) send_byte(CHAR_0 + 8'($urandom_range(9)), rare_eob());
    for (i = 0; i < n_fill; i++) send_byte(non_final_byte(), rare_eob());
    if ($urandom_range(9) < 6) fin = $urandom_range(1) ? CHAR_H : CHAR_F;
    else fin = 8'($urandom_range(CSI_FINAL_HI, CSI_FINAL_LO));
    send_byte(fin, $urandom_range(4) == 0);
  endtask

  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned i;
    int unsigned n;
    logic [7:0]  b;
    kind = $urandom_range(99);
    if (kind < 20) begin
      send_byte(8'($urandom_range(255)), rare_eob());
    end else if (kind < 60) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3);
      send_random_csi(n, $urandom_range(2));
    end else if (kind < 80) begin
      send_byte(CHAR_ESC, rare_eob());
      send_byte(CHAR_RBRACKET, rare_eob());
      n = $urandom_range(4);
      for (i = 0; i < n; i++) begin
        do b = 8'($urandom_range(255)); while (b == CHAR_BEL || b == CHAR_ESC);
        send_byte(b, rare_eob());
      end
      if ($urandom_range(9) < 6) begin
        send_byte(CHAR_BEL, $urandom_range(4) == 0);
      end else begin
        send_byte(CHAR_ESC, rare_eob());
        send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
      end
    end else if (kind < 92) begin
      send_byte(CHAR_ESC, rare_eob());
      send_byte(8'($urandom_range(255)), rare_eob());
    end else begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), rare_eob());
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_escape_pair();
    send_byte(CHAR_ESC, 1'b0);
    send_text("x", 1'b0);
  endtask

  task automatic test_cursor_moves();
    send_byte(CHAR_ESC, 1'b0);
    send_text("[5H", 1'b0);
    // row 30 is past the 24-row limit: keep row 4
    send_byte(CHAR_ESC, 1'b0);
    send_text("[30H", 1'b0);
    send_byte(CHAR_ESC, 1'b0);
    send_text("[0f", 1'b0);
    send_byte(CHAR_ESC, 1'b0);
    send_text("[H", 1'b0);
  endtask

  task automatic test_osc_strings();
    send_byte(CHAR_ESC, 1'b0);
    send_byte(CHAR_RBRACKET, 1'b0);
    send_byte(CHAR_BEL, 1'b0);
    send_byte(CHAR_ESC, 1'b0);
    send_byte(CHAR_RBRACKET, 1'b0);
    send_byte(CHAR_ESC, 1'b0);
    send_text("\\", 1'b0);
  endtask

  task automatic test_end_of_buffer();
    send_byte(CHAR_ESC, 1'b0);
    send_text("[3", 1'b1);
    send_text("z", 1'b0);
  endtask

  // Nearly fill or overrun the CSI buffer; by the fill the final byte is kept or dropped
  task automatic test_buffer_overflow();
    int unsigned i;
    int unsigned n_fill;
    n_fill = $urandom_range(61, 57);
    send_byte(CHAR_ESC, 1'b0);
    send_text("[12", 1'b0);
    for (i = 0; i < n_fill; i++) send_byte(non_final_byte(), 1'b0);
    send_byte(CHAR_H, 1'b0);
    drain_results();
  endtask

  task automatic test_random_phase(input logic [ROW_COUNT_W-1:0] rows,
                                   input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned start;
    set_row_count(rows);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_random_sequence();
    drain_results();
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.data_byte     = 8'h00;
    in_if.end_of_buffer = 1'b0;
    out_if.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    rst_ni              = 1'b0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    mismatches          = 0;
    items_sent          = 0;
    cycles              = 0;
    row_count_q         = ROW_COUNT_RESET;
    clear_parser();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_bytes();
    test_escape_pair();
    test_cursor_moves();
    test_osc_strings();
    test_end_of_buffer();
    drain_results();

    test_random_phase(9'd1, 0, 0);
    test_random_phase(9'd256, 50, 0);
    test_buffer_overflow();
    test_random_phase(ROW_COUNT_W'($urandom_range(256, 1)), 0, 50);
    test_random_phase(ROW_COUNT_RESET, 33, 33);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
